// ----- src/sbpe_pkg.sv -----
package sbpe_pkg;

    localparam int unsigned MAX_ARGS = 3;

    localparam logic [7:0] SYNC_BYTE    = 8'hFF;
    localparam logic [7:0] BROADCAST_ID = 8'hFE;
    localparam logic [7:0] OP_READ_DATA = 8'h02;
    localparam logic [3:0] BASE_LEN     = 4'd6;
    localparam logic [3:0] LEN_CAP      = 4'd15;

    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_RX      = 1'b1;
    localparam logic KIND_TX      = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    localparam int unsigned PC_W = 4;
    localparam logic [PC_W-1:0] PC_TX_ENTRY = 4'd0;
    localparam logic [PC_W-1:0] PC_CHECKSUM = 4'd8;
    localparam logic [PC_W-1:0] PC_RX_ENTRY = 4'd9;

    typedef struct packed {
        logic       mode;
        logic [7:0] servo_id;
        logic [7:0] opcode;
        logic [1:0] arg_count;
        logic [7:0] arg_first;
        logic [7:0] arg_second;
        logic [7:0] arg_third;
        logic [7:0] rx_byte;
    } cmd_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       last;
        logic       header_error;
        logic       checksum_error;
        logic [7:0] servo_error;
        logic [1:0] data_count;
        logic [7:0] data_low;
        logic [7:0] data_high;
    } rsp_item_t;

    typedef enum logic [3:0] {
        SEL_NONE,
        SEL_SYNC,
        SEL_ID,
        SEL_LEN,
        SEL_OP,
        SEL_ARG0,
        SEL_ARG1,
        SEL_ARG2,
        SEL_SUM
    } byte_sel_t;

    typedef struct packed {
        byte_sel_t       sel;
        logic            emit;
        logic            accum;
        logic            jump_en;
        logic [1:0]      jump_args;
        logic [PC_W-1:0] jump_to;
        logic            last;
        logic            finish;
        logic            arm;
        logic            rx;
    } ucode_t;

    typedef struct packed {
        logic arm;
        logic rx_step;
    } reply_ctl_t;

    typedef struct packed {
        logic       is_final;
        logic       header_error;
        logic       checksum_error;
        logic [7:0] servo_error;
        logic [1:0] data_count;
        logic [7:0] data_low;
        logic [7:0] data_high;
    } reply_stat_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{sel: SEL_NONE, emit: 1'b0, accum: 1'b0, jump_en: 1'b0, jump_args: 2'd0,
              jump_to: PC_CHECKSUM, last: 1'b0, finish: 1'b1, arm: 1'b0, rx: 1'b0};
        unique case (pc)
            4'd0:
            begin
                w.sel = SEL_SYNC; w.emit = 1'b1; w.finish = 1'b0;
            end
            4'd1:
            begin
                w.sel = SEL_SYNC; w.emit = 1'b1; w.finish = 1'b0;
            end
            4'd2:
            begin
                w.sel = SEL_ID; w.emit = 1'b1; w.accum = 1'b1; w.finish = 1'b0;
            end
            4'd3:
            begin
                w.sel = SEL_LEN; w.emit = 1'b1; w.accum = 1'b1; w.finish = 1'b0;
            end
            4'd4:
            begin
                w.sel = SEL_OP; w.emit = 1'b1; w.accum = 1'b1; w.finish = 1'b0;
                w.jump_en = 1'b1; w.jump_args = 2'd0;
            end
            4'd5:
            begin
                w.sel = SEL_ARG0; w.emit = 1'b1; w.accum = 1'b1; w.finish = 1'b0;
                w.jump_en = 1'b1; w.jump_args = 2'd1;
            end
            4'd6:
            begin
                w.sel = SEL_ARG1; w.emit = 1'b1; w.accum = 1'b1; w.finish = 1'b0;
                w.jump_en = 1'b1; w.jump_args = 2'd2;
            end
            4'd7:
            begin
                w.sel = SEL_ARG2; w.emit = 1'b1; w.accum = 1'b1; w.finish = 1'b0;
            end
            4'd8:
            begin
                w.sel = SEL_SUM; w.emit = 1'b1; w.last = 1'b1; w.arm = 1'b1;
            end
            4'd9:
            begin
                w.rx = 1'b1;
            end
            default:
            begin
                w.finish = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- src/sbpe_reply.sv -----
module sbpe_reply
    import sbpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  reply_ctl_t  ctl,
    input  cmd_item_t   item,
    output reply_stat_t stat
);

    logic       awaiting_reg, awaiting_next;
    logic [3:0] exp_len_reg, exp_len_next;
    logic [7:0] exp_id_reg, exp_id_next;
    logic [3:0] count_reg, count_next;
    logic [7:0] sum_reg, sum_next;
    logic       hdr_bad_reg, hdr_bad_next;
    logic [7:0] err_reg, err_next;
    logic [7:0] data0_reg, data0_next;
    logic [7:0] data1_reg, data1_next;

    logic [3:0] fin;
    logic [3:0] req_len;
    logic       chk_bad;
    logic [1:0] cnt;

    assign fin     = exp_len_reg - 4'd1;
    assign chk_bad = item.rx_byte != ~sum_reg;

    always_comb
    begin
        if (item.opcode != OP_READ_DATA) begin
            req_len = BASE_LEN;
        end else if (item.arg_second > 8'(LEN_CAP - BASE_LEN)) begin
            req_len = LEN_CAP;
        end else begin
            req_len = BASE_LEN + item.arg_second[3:0];
        end
    end

    always_comb
    begin
        cnt = 2'd0;
        if (!chk_bad) begin
            if (exp_len_reg == 4'd7) begin
                cnt = 2'd1;
            end else if (exp_len_reg == 4'd8) begin
                cnt = 2'd2;
            end
        end
    end

    always_comb
    begin
        stat.is_final       = awaiting_reg && (count_reg >= fin);
        stat.header_error   = hdr_bad_reg;
        stat.checksum_error = chk_bad;
        stat.servo_error    = err_reg;
        stat.data_count     = cnt;
        stat.data_low       = (cnt != 2'd0) ? data0_reg : 8'h00;
        stat.data_high      = (cnt == 2'd2) ? data1_reg : 8'h00;
    end

    always_comb
    begin
        awaiting_next = awaiting_reg;
        exp_len_next  = exp_len_reg;
        exp_id_next   = exp_id_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        hdr_bad_next  = hdr_bad_reg;
        err_next      = err_reg;
        data0_next    = data0_reg;
        data1_next    = data1_reg;
        if (ctl.arm) begin
            count_next    = 4'd0;
            sum_next      = 8'h00;
            hdr_bad_next  = 1'b0;
            err_next      = 8'h00;
            data0_next    = 8'h00;
            data1_next    = 8'h00;
            awaiting_next = item.servo_id != BROADCAST_ID;
            if (item.servo_id != BROADCAST_ID) begin
                exp_id_next  = item.servo_id;
                exp_len_next = req_len;
            end
        end else if (ctl.rx_step && awaiting_reg) begin
            if (stat.is_final) begin
                awaiting_next = 1'b0;
                count_next    = 4'd0;
                sum_next      = 8'h00;
                hdr_bad_next  = 1'b0;
                err_next      = 8'h00;
                data0_next    = 8'h00;
                data1_next    = 8'h00;
            end else begin
                case (count_reg)
                    4'd0, 4'd1:
                    begin
                        if (item.rx_byte != SYNC_BYTE) hdr_bad_next = 1'b1;
                    end
                    4'd2:
                    begin
                        if (item.rx_byte != exp_id_reg) hdr_bad_next = 1'b1;
                    end
                    4'd3:
                    begin
                        if (item.rx_byte != {4'h0, exp_len_reg - 4'd4}) hdr_bad_next = 1'b1;
                    end
                    4'd4: err_next = item.rx_byte;
                    4'd5: data0_next = item.rx_byte;
                    4'd6: data1_next = item.rx_byte;
                    default: ;
                endcase
                if (count_reg >= 4'd2) begin
                    sum_next = sum_reg + item.rx_byte;
                end
                count_next = count_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            awaiting_reg <= 1'b0;
            exp_len_reg  <= 4'd0;
            exp_id_reg   <= 8'h00;
            count_reg    <= 4'd0;
            sum_reg      <= 8'h00;
            hdr_bad_reg  <= 1'b0;
            err_reg      <= 8'h00;
            data0_reg    <= 8'h00;
            data1_reg    <= 8'h00;
        end else begin
            awaiting_reg <= awaiting_next;
            exp_len_reg  <= exp_len_next;
            exp_id_reg   <= exp_id_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            hdr_bad_reg  <= hdr_bad_next;
            err_reg      <= err_next;
            data0_reg    <= data0_next;
            data1_reg    <= data1_next;
        end
    end

endmodule

// ----- src/servo_bus_packet_engine.sv -----
// Channel   Valid       Stall       Payload
// cmd       cmd_valid   cmd_stall   cmd  (cmd_item_t: request or one reply byte)
// rsp       rsp_valid   rsp_stall   rsp  (rsp_item_t: frame byte or reply report)
//
// A request item runs through the microcode program one step per cycle, waiting while
// the output register is full and stalled, and emits one frame byte per step. A reply
// byte runs the receive step, which reports only on the final byte of an awaited reply.
// Reset clears the sequencer, the output valid flag and the reply state.
module servo_bus_packet_engine
    import sbpe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    logic            busy_reg, busy_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic [7:0]      sum_reg, sum_next;
    cmd_item_t       item_reg, item_next;
    logic            rsp_valid_reg, rsp_valid_next;
    rsp_item_t       rsp_reg, rsp_next;

    ucode_t      uw;
    reply_ctl_t  rctl;
    reply_stat_t rstat;
    logic        out_ready;
    logic        step;
    logic [1:0]  nargs;
    logic [7:0]  cur_byte;

    sbpe_reply u_reply (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (rctl),
        .item  (item_reg),
        .stat  (rstat)
    );

    assign uw        = ucode_rom(pc_reg);
    assign out_ready = !rsp_valid_reg || !rsp_stall;
    assign step      = busy_reg && out_ready;
    assign cmd_stall = busy_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign nargs     = (32'(item_reg.arg_count) > MAX_ARGS) ? 2'(MAX_ARGS)
                                                            : item_reg.arg_count;

    assign rctl.arm     = step && uw.arm;
    assign rctl.rx_step = step && uw.rx;

    always_comb
    begin
        unique case (uw.sel)
            SEL_SYNC: cur_byte = SYNC_BYTE;
            SEL_ID:   cur_byte = item_reg.servo_id;
            SEL_LEN:  cur_byte = 8'd2 + {6'd0, nargs};
            SEL_OP:   cur_byte = item_reg.opcode;
            SEL_ARG0: cur_byte = item_reg.arg_first;
            SEL_ARG1: cur_byte = item_reg.arg_second;
            SEL_ARG2: cur_byte = item_reg.arg_third;
            SEL_SUM:  cur_byte = ~sum_reg;
            default:  cur_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        sum_next       = sum_reg;
        item_next      = item_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        if (!busy_reg) begin
            if (cmd_valid) begin
                item_next = cmd;
                busy_next = 1'b1;
                sum_next  = 8'h00;
                pc_next   = (cmd.mode == MODE_RX) ? PC_RX_ENTRY : PC_TX_ENTRY;
            end
        end else if (step) begin
            if (uw.accum) begin
                sum_next = sum_reg + cur_byte;
            end
            if (uw.emit) begin
                rsp_valid_next = 1'b1;
                rsp_next       = '0;
                rsp_next.kind  = KIND_TX;
                rsp_next.tx_byte = cur_byte;
                rsp_next.last  = uw.last;
            end else if (uw.rx && rstat.is_final) begin
                rsp_valid_next         = 1'b1;
                rsp_next.kind          = KIND_REPORT;
                rsp_next.tx_byte       = 8'h00;
                rsp_next.last          = 1'b1;
                rsp_next.header_error  = rstat.header_error;
                rsp_next.checksum_error = rstat.checksum_error;
                rsp_next.servo_error   = rstat.servo_error;
                rsp_next.data_count    = rstat.data_count;
                rsp_next.data_low      = rstat.data_low;
                rsp_next.data_high     = rstat.data_high;
            end
            if (uw.finish) begin
                busy_next = 1'b0;
            end else if (uw.jump_en && (nargs == uw.jump_args)) begin
                pc_next = uw.jump_to;
            end else begin
                pc_next = pc_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            pc_reg        <= PC_TX_ENTRY;
            rsp_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        item_reg <= item_next;
        rsp_reg  <= rsp_next;
    end

endmodule

// ----- dv/servo_bus_packet_engine_tb.sv -----
`timescale 1ns / 1ps

module servo_bus_packet_engine_tb;
    import sbpe_pkg::*;

    localparam int unsigned NO_FLIP = 99;

    class frame_reply_tracker;
        rsp_item_t owed[$];
        int unsigned fails;
        logic awaiting;
        logic [3:0] reply_len;
        logic [7:0] reply_id;
        logic [3:0] got_count;
        logic [7:0] sum_acc;
        logic hdr_bad;
        logic [7:0] err_seen;
        logic [7:0] data_seen [2];

        function new();
            fails = 0;
            awaiting = 1'b0;
            reply_len = '0;
            reply_id = '0;
            clear_reply();
        endfunction

        function void clear_reply();
            got_count = '0;
            sum_acc = '0;
            hdr_bad = 1'b0;
            err_seen = '0;
            data_seen[0] = '0;
            data_seen[1] = '0;
        endfunction

        // Returns 1 unless the item is a reply byte that arrives while no reply is awaited.
        function bit note_command(cmd_item_t c);
            rsp_item_t r;
            logic [7:0] frame [9];
            logic [7:0] sum;
            logic [7:0] b;
            int unsigned n;
            int unsigned size;
            int unsigned want;
            int unsigned idx;
            int unsigned fin;
            logic chk_bad;
            logic [1:0] cnt;
            if (c.mode == MODE_REQUEST)
            begin
                n = c.arg_count;
                if (n > MAX_ARGS)
                    n = MAX_ARGS;
                frame[0] = SYNC_BYTE;
                frame[1] = SYNC_BYTE;
                frame[2] = c.servo_id;
                frame[3] = 8'(2 + n);
                frame[4] = c.opcode;
                frame[5] = c.arg_first;
                frame[6] = c.arg_second;
                frame[7] = c.arg_third;
                size = BASE_LEN + n;
                sum = '0;
                for (int i = 2; i < size - 1; i++)
                    sum += frame[i];
                frame[size - 1] = ~sum;
                for (int i = 0; i < size; i++)
                begin
                    r = '0;
                    r.kind = KIND_TX;
                    r.tx_byte = frame[i];
                    r.last = (i == size - 1);
                    owed.push_back(r);
                end
                awaiting = 1'b0;
                clear_reply();
                if (c.servo_id != BROADCAST_ID)
                begin
                    want = BASE_LEN;
                    if (c.opcode == OP_READ_DATA)
                    begin
                        want = BASE_LEN + c.arg_second;
                        if (want > LEN_CAP)
                            want = LEN_CAP;
                    end
                    awaiting = 1'b1;
                    reply_id = c.servo_id;
                    reply_len = want[3:0];
                end
                return 1'b1;
            end
            if (!awaiting)
                return 1'b0;
            b = c.rx_byte;
            idx = got_count;
            fin = reply_len - 1;
            if (idx < 2)
            begin
                if (b != SYNC_BYTE)
                    hdr_bad = 1'b1;
            end
            else if (idx == 2)
            begin
                if (b != reply_id)
                    hdr_bad = 1'b1;
            end
            else if (idx == 3)
            begin
                if (int'(b) != int'(reply_len) - 4)
                    hdr_bad = 1'b1;
            end
            else if (idx == 4)
                err_seen = b;
            if (idx < fin)
            begin
                if (idx == 5)
                    data_seen[0] = b;
                else if (idx == 6)
                    data_seen[1] = b;
                if (idx >= 2)
                    sum_acc += b;
                got_count = 4'(idx + 1);
                return 1'b1;
            end
            chk_bad = (b != ~sum_acc);
            cnt = 2'd0;
            if (!chk_bad)
            begin
                if (reply_len == 4'd7)
                    cnt = 2'd1;
                else if (reply_len == 4'd8)
                    cnt = 2'd2;
            end
            r = '0;
            r.kind = KIND_REPORT;
            r.last = 1'b1;
            r.header_error = hdr_bad;
            r.checksum_error = chk_bad;
            r.servo_error = err_seen;
            r.data_count = cnt;
            r.data_low = (cnt >= 2'd1) ? data_seen[0] : 8'h00;
            r.data_high = (cnt == 2'd2) ? data_seen[1] : 8'h00;
            owed.push_back(r);
            awaiting = 1'b0;
            clear_reply();
            return 1'b1;
        endfunction

        function string fmt_rsp(rsp_item_t r);
            return {$sformatf("kind=%0d tx=%02h last=%0d hdr=%0d", r.kind, r.tx_byte, r.last,
                              r.header_error),
                    $sformatf(" chk=%0d err=%02h cnt=%0d lo=%02h hi=%02h", r.checksum_error,
                              r.servo_error, r.data_count, r.data_low, r.data_high)};
        endfunction

        function void log_fail(string what, rsp_item_t want, rsp_item_t got);
            fails++;
            if (fails <= 10)
            begin
                $display("%0t %s: expected %s", $realtime, what, fmt_rsp(want));
                $display("    got %s", fmt_rsp(got));
            end
        endfunction

        function void check_result(rsp_item_t got);
            rsp_item_t want;
            if (owed.size() == 0)
            begin
                log_fail("result with nothing pending", '0, got);
                return;
            end
            want = owed.pop_front();
            if (got.kind !== want.kind || got.tx_byte !== want.tx_byte
                || got.last !== want.last || got.header_error !== want.header_error
                || got.checksum_error !== want.checksum_error
                || got.servo_error !== want.servo_error || got.data_count !== want.data_count
                || got.data_low !== want.data_low || got.data_high !== want.data_high)
                log_fail("mismatch", want, got);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_item_t cmd = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_item_t rsp;

    int unsigned send_idle = 0;
    int unsigned stall_pct = 0;
    int unsigned items_sent = 0;
    frame_reply_tracker sb = new();

    servo_bus_packet_engine dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(rsp);
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        #5000000;
        $display("servo_bus_packet_engine_tb: done, errors");
        $finish;
    end

    function automatic cmd_item_t rand_cmd();
        logic [63:0] raw;
        cmd_item_t c;
        raw = {$urandom, $urandom};
        c = raw[$bits(cmd_item_t)-1:0];
        c.servo_id = 8'($urandom_range(254));
        return c;
    endfunction

    task automatic send_item(input cmd_item_t c);
        while ($urandom_range(99) < send_idle)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        if (sb.note_command(c))
            items_sent++;
    endtask

    task automatic send_request(input logic [7:0] id, input logic [7:0] op,
                                input logic [1:0] nargs, input logic [7:0] a0,
                                input logic [7:0] a1, input logic [7:0] a2);
        cmd_item_t c;
        c = rand_cmd();
        c.mode = MODE_REQUEST;
        c.servo_id = id;
        c.opcode = op;
        c.arg_count = nargs;
        c.arg_first = a0;
        c.arg_second = a1;
        c.arg_third = a2;
        send_item(c);
    endtask

    task automatic send_reply(input logic [7:0] id, input int unsigned len,
                              input logic [7:0] err, input int unsigned flip_at,
                              input int unsigned count);
        logic [7:0] bytes [15];
        logic [7:0] sum;
        cmd_item_t c;
        bytes[0] = SYNC_BYTE;
        bytes[1] = SYNC_BYTE;
        bytes[2] = id;
        bytes[3] = 8'(len - 4);
        bytes[4] = err;
        sum = id + bytes[3] + err;
        for (int i = 5; i < len - 1; i++)
        begin
            bytes[i] = 8'($urandom);
            sum += bytes[i];
        end
        bytes[len - 1] = ~sum;
        for (int i = 0; i < count; i++)
        begin
            c = rand_cmd();
            c.mode = MODE_RX;
            c.rx_byte = bytes[i];
            if (i == flip_at)
                c.rx_byte ^= 8'($urandom_range(1, 255));
            send_item(c);
        end
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.owed.size() != 0);
    endtask

    task automatic random_sequence();
        cmd_item_t c;
        int unsigned len;
        int unsigned pick;
        c = rand_cmd();
        c.mode = MODE_REQUEST;
        if ($urandom_range(9) == 0)
            c.servo_id = BROADCAST_ID;
        else
            c.servo_id = 8'($urandom_range(253));
        if ($urandom_range(1) == 0)
        begin
            c.opcode = OP_READ_DATA;
            pick = $urandom_range(9);
            if (pick < 7)
                c.arg_second = 8'($urandom_range(2));
            else if (pick < 9)
                c.arg_second = 8'($urandom_range(3, 9));
            else
                c.arg_second = 8'($urandom_range(10, 255));
        end
        send_item(c);
        len = 0;
        if (c.servo_id != BROADCAST_ID)
        begin
            len = BASE_LEN;
            if (c.opcode == OP_READ_DATA)
            begin
                len = BASE_LEN + c.arg_second;
                if (len > LEN_CAP)
                    len = LEN_CAP;
            end
        end
        pick = $urandom_range(99);
        if (len != 0 && pick < 70)
            send_reply(c.servo_id, len, ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom),
                       ($urandom_range(9) == 0) ? $urandom_range(len - 1) : NO_FLIP, len);
        else if (len != 0 && pick < 80)
            send_reply(c.servo_id, len, 8'($urandom), NO_FLIP, $urandom_range(1, len - 1));
        else
        begin
            pick = $urandom_range(3);
            for (int i = 0; i < pick; i++)
            begin
                c = rand_cmd();
                c.mode = MODE_RX;
                send_item(c);
            end
        end
        if ($urandom_range(19) == 0)
            drain();
    endtask

    task automatic run_phase(input int unsigned idle, input int unsigned stall,
                             input int unsigned target);
        send_idle = idle;
        stall_pct = stall;
        while (items_sent < target)
            random_sequence();
    endtask

    initial
    begin
        cmd_item_t c;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        c = rand_cmd();
        c.mode = MODE_RX;
        c.rx_byte = 8'h00;
        send_item(c);
        send_request(BROADCAST_ID, 8'h03, 2'd3, 8'hFF, 8'h00, 8'hAA);
        send_request(8'h00, OP_READ_DATA, 2'd0, 8'h00, 8'h01, 8'h55);
        send_reply(8'h00, 7, 8'h00, NO_FLIP, 7);
        send_request(8'hFD, OP_READ_DATA, 2'd2, 8'h24, 8'hFF, 8'h00);
        send_reply(8'hFD, 15, 8'h00, NO_FLIP, 1);
        send_request(8'h01, 8'hFF, 2'd1, 8'h80, 8'h7F, 8'h01);
        send_reply(8'h01, 6, 8'h80, 2, 6);
        send_request(8'h7F, OP_READ_DATA, 2'd2, 8'h2B, 8'h02, 8'hFF);
        send_reply(8'h7F, 8, 8'h21, NO_FLIP, 8);
        drain();

        run_phase(0, 0, 95);
        run_phase(83, 0, 190);
        run_phase(0, 83, 285);
        run_phase(24, 24, 380);

        cmd_valid <= 1'b0;
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.fails == 0 && sb.owed.size() == 0)
            $display("servo_bus_packet_engine_tb: done, clean");
        else
            $display("servo_bus_packet_engine_tb: done, errors");
        $finish;
    end

endmodule
